### rtl/core/cpl_pkg.sv
// shared types, widths and color packing for the cursor palette lookup
package cpl_pkg;

   localparam int IDX_W   = 8;
   localparam int CHAN_W  = 8;
   localparam int COLOR_W = 16;
   localparam int KIND_W  = 2;

   // request kinds; the remaining code is ignored
   typedef enum logic [KIND_W-1:0] {
      REQ_PALETTE_WRITE = 2'd0,
      REQ_SET_KEY       = 2'd1,
      REQ_LOOKUP        = 2'd2
   } req_kind_type;

   // value left in an entry once it stops being the key entry
   localparam logic [COLOR_W-1:0] KEY_RELEASE = 16'h0001;

   // rgb888 to rgba5551, alpha set
   function automatic logic [COLOR_W-1:0] pack5551(input logic [CHAN_W-1:0] r,
                                                   input logic [CHAN_W-1:0] g,
                                                   input logic [CHAN_W-1:0] b);
      return {r[CHAN_W-1:3], g[CHAN_W-1:3], b[CHAN_W-1:3], 1'b1};
   endfunction

endpackage

### rtl/core/cpl_req_if.sv
// request channel: palette writes, key changes and pixel lookups
interface cpl_req_if;
   logic                       valid;
   logic                       ready;
   logic [cpl_pkg::KIND_W-1:0] req_type;
   logic [cpl_pkg::IDX_W-1:0]  entry_index;
   logic [cpl_pkg::CHAN_W-1:0] red;
   logic [cpl_pkg::CHAN_W-1:0] green;
   logic [cpl_pkg::CHAN_W-1:0] blue;
   logic                       end_of_image;

   modport source (output valid, req_type, entry_index, red, green, blue, end_of_image,
                   input ready);
   modport sink (input valid, req_type, entry_index, red, green, blue, end_of_image,
                 output ready);
endinterface

### rtl/core/cpl_rsp_if.sv
// response channel: looked-up pixel colors
interface cpl_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [cpl_pkg::COLOR_W-1:0] pixel_color;
   logic                        last;

   modport source (output valid, pixel_color, last, input ready);
   modport sink (input valid, pixel_color, last, output ready);
endinterface

### rtl/core/cursor_palette_lookup.sv
// cursor palette lookup: palette memory, color key handling and response register
// a lookup request passes through the memory read register, then the output register, before it answers
// throughput: one request per cycle; req.ready drops only while both stages hold
//   pixels and the response side stalls
// writes and key changes take effect at the edge they are accepted and give no response
// reset clears the per-entry valid bits, the loaded flag, the key index and the stage valid flags
module cursor_palette_lookup #(
   parameter int PALETTE_ENTRIES = 256
) (
   input logic        clock,
   input logic        reset,
   cpl_req_if.sink    req,
   cpl_rsp_if.source  rsp
);

   localparam int ADDR_W = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
   localparam logic [cpl_pkg::IDX_W:0] ENTRY_LIMIT = (cpl_pkg::IDX_W + 1)'(PALETTE_ENTRIES);

   logic [cpl_pkg::COLOR_W-1:0] mem [PALETTE_ENTRIES];
   logic [PALETTE_ENTRIES-1:0]  valid_ff;

   logic                        loaded_ff, loaded_in;
   logic [cpl_pkg::IDX_W-1:0]   key_ff, key_in;

   logic                        s1_vld_ff, s1_vld_in;
   logic                        s1_loaded_ff;
   logic                        s1_use_mem_ff;
   logic [cpl_pkg::IDX_W-1:0]   s1_idx_ff;
   logic                        s1_last_ff;
   logic [cpl_pkg::COLOR_W-1:0] s1_rdata_ff;

   logic                        s2_vld_ff, s2_vld_in;
   logic [cpl_pkg::COLOR_W-1:0] s2_color_ff, s2_color_in;
   logic                        s2_last_ff;

   logic                        s2_en;
   logic                        req_fire;
   logic                        is_lookup;
   logic                        idx_in_range;
   logic                        key_in_range;
   logic [ADDR_W-1:0]           idx_a;
   logic [ADDR_W-1:0]           key_a;
   logic                        wr_en;
   logic [ADDR_W-1:0]           wr_addr;
   logic [cpl_pkg::COLOR_W-1:0] wr_data;
   logic                        use_mem;

   assign s2_en     = !s2_vld_ff || rsp.ready;
   assign req.ready = !s1_vld_ff || s2_en;
   assign req_fire  = req.valid && req.ready;
   assign is_lookup = (req.req_type == cpl_pkg::REQ_LOOKUP);

   assign idx_in_range = ({1'b0, req.entry_index} < ENTRY_LIMIT);
   assign key_in_range = ({1'b0, key_ff} < ENTRY_LIMIT);
   assign idx_a        = req.entry_index[ADDR_W-1:0];
   assign key_a        = key_ff[ADDR_W-1:0];

   // the key entry always reads zero once loaded, so it is never stored as zero;
   // leaving the key role after loading writes the released value instead
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = idx_a;
      wr_data = cpl_pkg::pack5551(req.red, req.green, req.blue);
      case (req.req_type)
         cpl_pkg::REQ_PALETTE_WRITE: begin
            wr_en = req_fire && idx_in_range;
         end
         cpl_pkg::REQ_SET_KEY: begin
            wr_en   = req_fire && loaded_ff && key_in_range;
            wr_addr = key_a;
            wr_data = cpl_pkg::KEY_RELEASE;
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   assign use_mem = valid_ff[idx_a] && idx_in_range && (req.entry_index != key_ff);

   assign loaded_in = loaded_ff ||
                      (req_fire && (req.req_type == cpl_pkg::REQ_PALETTE_WRITE));
   assign key_in    = (req_fire && (req.req_type == cpl_pkg::REQ_SET_KEY)) ?
                      req.entry_index : key_ff;

   assign s1_vld_in = req_fire ? is_lookup : (s1_vld_ff && !s2_en);
   assign s2_vld_in = s2_en ? s1_vld_ff : s2_vld_ff;

   always_comb begin
      if (!s1_loaded_ff) begin
         s2_color_in = {{(cpl_pkg::COLOR_W - cpl_pkg::IDX_W){1'b0}}, s1_idx_ff};
      end else if (s1_use_mem_ff) begin
         s2_color_in = s1_rdata_ff;
      end else begin
         s2_color_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (req_fire && is_lookup) begin
         s1_rdata_ff <= mem[idx_a];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         loaded_ff <= 1'b0;
         key_ff    <= '0;
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         loaded_ff <= loaded_in;
         key_ff    <= key_in;
         s1_vld_ff <= s1_vld_in;
         s2_vld_ff <= s2_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && is_lookup) begin
         s1_loaded_ff  <= loaded_ff;
         s1_use_mem_ff <= use_mem;
         s1_idx_ff     <= req.entry_index;
         s1_last_ff    <= req.end_of_image;
      end
      if (s2_en && s1_vld_ff) begin
         s2_color_ff <= s2_color_in;
         s2_last_ff  <= s1_last_ff;
      end
   end

   assign rsp.valid       = s2_vld_ff;
   assign rsp.pixel_color = s2_color_ff;
   assign rsp.last        = s2_last_ff;

   a_no_rsp_for_updates: assert property (@(posedge clock) disable iff (reset)
      req_fire && !is_lookup |=> !s1_vld_ff)
      else $error("non-lookup request entered the pipeline");

   a_stage1_holds: assert property (@(posedge clock) disable iff (reset)
      s1_vld_ff && !s2_en |=> s1_vld_ff && $stable(s1_idx_ff) && $stable(s1_rdata_ff))
      else $error("stalled lookup lost its data");

   a_loaded_sticks: assert property (@(posedge clock) disable iff (reset)
      loaded_ff |=> loaded_ff)
      else $error("palette loaded flag cleared outside reset");

   a_key_reads_zero: assert property (@(posedge clock) disable iff (reset)
      req_fire && is_lookup && loaded_ff && (req.entry_index == key_ff)
      |=> s1_vld_ff && !s1_use_mem_ff)
      else $error("key entry lookup used stored color");

endmodule
